// ===== design/kss_pkg.sv =====
// Package with the sizes, codes and queue entry type of the keypad scanner.
package kss_pkg;

  localparam int KEY_ROWS    = 6;
  localparam int KEY_COLS    = 4;
  localparam int NUM_KEYS    = KEY_ROWS * KEY_COLS;
  localparam int COL_W       = (KEY_COLS > 1) ? $clog2(KEY_COLS) : 1;

  localparam int ROW_W       = 6;
  localparam int ROW_EXT_W   = 8;
  localparam int DRIVE_W     = 4;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 8;
  localparam int PERIOD_W    = 8;

  localparam int DISP_WRITES = 8;
  localparam int BEAT_W      = 3;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd50;

  localparam logic REQ_SCAN    = 1'b0;
  localparam logic REQ_REFRESH = 1'b1;

  localparam logic KIND_DRIVE  = 1'b0;
  localparam logic KIND_DISP   = 1'b1;

  // One queued command: a drive update for a column, or a full display
  // refresh carrying a snapshot of the latched lamps.
  typedef struct packed {
    logic                is_refresh;
    logic [COL_W-1:0]    column;
    logic [NUM_KEYS-1:0] lamps;
  } kss_cmd_t;

endpackage

// ===== design/kss_if.sv =====
// Valid/ready channel interfaces for the keypad scanner's input and result items.
interface kss_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] row_levels;

  modport source (output valid, output req_type, output row_levels, input ready);
  modport sink   (input valid, input req_type, input row_levels, output ready);
endinterface

interface kss_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [3:0] column_drive;
  logic [3:0] disp_address;
  logic [7:0] disp_data;
  logic       last_result;

  modport source (output valid, output result_kind, output column_drive,
                  output disp_address, output disp_data, output last_result,
                  input ready);
  modport sink   (input valid, input result_kind, input column_drive,
                  input disp_address, input disp_data, input last_result,
                  output ready);
endinterface

// ===== design/kss_front.sv =====
// Front end: accepts ticks, keeps scan, key and lamp state, queues commands.
module kss_front
  import kss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [ROW_W-1:0]    row_levels_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output kss_cmd_t            q_cmd_o
);

  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] pre_q, pre_inc;
  logic [COL_W-1:0]    col_q, col_next;
  logic [NUM_KEYS-1:0] keys_q, keys_scan;
  logic [NUM_KEYS-1:0] lamps_q, lamps_fire;
  logic [ROW_EXT_W-1:0] rows_ext;
  logic                accept, fire;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    col_next   = (col_q == COL_W'(KEY_COLS - 1)) ? '0 : col_q + 1'b1;
    // Rows past the sampled field read as released.
    rows_ext   = {{(ROW_EXT_W - ROW_W){1'b1}}, row_levels_i};
    keys_scan  = keys_q;
    for (int r = 0; r < KEY_ROWS; r++) begin
      for (int c = 0; c < KEY_COLS; c++) begin
        if (col_next == COL_W'(c)) begin
          keys_scan[r*KEY_COLS + c] = rows_ext[r];
        end
      end
    end
    pre_inc    = pre_q + 1'b1;
    fire       = !(pre_inc < period_q);
    lamps_fire = lamps_q | ~keys_q;
  end

  always_comb begin
    q_push_o = accept && ((req_type_i == REQ_SCAN) || fire);
    q_cmd_o.is_refresh = (req_type_i == REQ_REFRESH);
    q_cmd_o.column     = col_next;
    q_cmd_o.lamps      = lamps_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      pre_q    <= '0;
      col_q    <= '0;
      keys_q   <= '1;
      lamps_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (req_type_i == REQ_SCAN) begin
          col_q  <= col_next;
          keys_q <= keys_scan;
        end else if (fire) begin
          pre_q   <= '0;
          lamps_q <= lamps_fire;
        end else begin
          pre_q <= pre_inc;
        end
      end
    end
  end

endmodule

// ===== design/kss_queue.sv =====
// Small register queue of commands between the front and back ends.
module kss_queue
  import kss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  kss_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output kss_cmd_t head_cmd_o
);

  kss_cmd_t          entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/kss_back.sv =====
// Back end: turns queued commands into drive updates and display writes.
module kss_back
  import kss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  kss_cmd_t          head_cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              result_kind_o,
  output logic [DRIVE_W-1:0] column_drive_o,
  output logic [ADDR_W-1:0] disp_address_o,
  output logic [DATA_W-1:0] disp_data_o,
  output logic              last_result_o
);

  logic [BEAT_W-1:0]  beat_q;
  logic               vld_q;
  logic               kind_q, last_q;
  logic [DRIVE_W-1:0] drive_q, drive_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [DATA_W-1:0]  data_q, data_d;
  logic               load, final_beat;

  assign load       = head_valid_i && (!vld_q || out_ready_i);
  assign final_beat = !head_cmd_i.is_refresh || (beat_q == BEAT_W'(DISP_WRITES - 1));
  assign pop_o      = load && final_beat;

  always_comb begin
    drive_d = '0;
    addr_d  = '0;
    data_d  = '0;
    if (head_cmd_i.is_refresh) begin
      addr_d = ADDR_W'({1'b0, beat_q}) + 1'b1;
      for (int r = 0; r < KEY_ROWS; r++) begin
        for (int c = 0; c < KEY_COLS; c++) begin
          if (beat_q == BEAT_W'(r)) begin
            data_d[DATA_W-1-c] = head_cmd_i.lamps[r*KEY_COLS + c];
          end
        end
      end
    end else begin
      // One-cold drive; columns past the field leave it all ones.
      for (int c = 0; c < DRIVE_W; c++) begin
        drive_d[c] = (c >= KEY_COLS) || (head_cmd_i.column != COL_W'(c));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= head_cmd_i.is_refresh ? KIND_DISP : KIND_DRIVE;
      last_q  <= final_beat;
      drive_q <= drive_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= '0;
    end else begin
      if (load) begin
        vld_q  <= 1'b1;
        beat_q <= final_beat ? '0 : beat_q + 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = vld_q;
  assign result_kind_o  = kind_q;
  assign column_drive_o = drive_q;
  assign disp_address_o = addr_q;
  assign disp_data_o    = data_q;
  assign last_result_o  = last_q;

endmodule

// ===== design/keypad_scan_latched_led_refresh.sv =====
// Top level of the keypad matrix scanner with latched key lamps and display refresh.
//
// This block scans a 6-row by 4-column key matrix and keeps a sticky lamp for
// each key. A scan tick item (req_type 0) moves the driven column on by one,
// wrapping from the last column to the first, so the first scan after reset
// drives the second column; it stores the sampled row levels for that column
// (0 means pressed) and yields one result item with the active-low column
// drive. A refresh tick item (req_type 1) advances a prescaler; when it
// reaches refresh_period the prescaler clears, every key stored as pressed
// sets its lamp until reset, and eight display write result items follow at
// addresses 1 to 8, with the lamp of column c at bit 7-c of rows 1 to 6 and
// zero data at 7 and 8. A refresh tick that does not reach the period yields
// no result. The front end accepts one item per cycle whenever its four-entry
// command queue has room, and the back end delivers one result item per cycle
// through a registered output stage while the output is ready, so scan ticks
// run back to back while a triggering refresh occupies the output for its
// eight display writes; that output port is what sets the rate. The period
// register may be written only while no item is in flight.
module keypad_scan_latched_led_refresh
  import kss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_wdata_i,
  kss_in_if.sink              in_i,
  kss_out_if.source           out_o
);

  // Command path from the front end into the queue, and out of it.
  logic     q_push, q_full, q_pop, q_head_valid;
  kss_cmd_t q_push_cmd, q_head_cmd;

  kss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .req_type_i   (in_i.req_type),
    .row_levels_i (in_i.row_levels),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_push_cmd)
  );

  // The queue lets scan bookkeeping continue while a refresh drains.
  kss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (q_push_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_cmd_o   (q_head_cmd)
  );

  kss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_head_valid),
    .head_cmd_i     (q_head_cmd),
    .pop_o          (q_pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_kind_o  (out_o.result_kind),
    .column_drive_o (out_o.column_drive),
    .disp_address_o (out_o.disp_address),
    .disp_data_o    (out_o.disp_data),
    .last_result_o  (out_o.last_result)
  );

endmodule

// ===== design/kss_checker.sv =====
// Port-level checker for the keypad scanner, bound to the top level.
module kss_checker
  import kss_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       result_kind_i,
  input logic [3:0] column_drive_i,
  input logic [3:0] disp_address_i,
  input logic [7:0] disp_data_i,
  input logic       last_result_i
);

  // A held result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(disp_address_i)
      && $stable(disp_data_i) && $stable(column_drive_i)))
    else $error("result changed while stalled");

  // A drive update is a single item with at most one column pulled low.
  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !result_kind_i) |-> (last_result_i && disp_address_i == 4'd0
      && disp_data_i == 8'd0 && $countones(~column_drive_i) <= 1))
    else $error("malformed drive update");

  // Only the eighth display write closes a refresh; rows past the last key row are blank.
  a_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && result_kind_i) |-> (column_drive_i == 4'd0
      && last_result_i == (disp_address_i == 4'd8)
      && (disp_address_i <= 4'(KEY_ROWS) || disp_data_i == 8'd0)))
    else $error("malformed display write");

  // Display writes of one refresh come out without gaps, addresses counting up.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && result_kind_i && !last_result_i) |=>
      (out_valid_i && result_kind_i && disp_address_i == $past(disp_address_i) + 4'd1))
    else $error("refresh burst broken");

endmodule

bind keypad_scan_latched_led_refresh kss_checker u_kss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_kind_i  (out_o.result_kind),
  .column_drive_i (out_o.column_drive),
  .disp_address_i (out_o.disp_address),
  .disp_data_i    (out_o.disp_data),
  .last_result_i  (out_o.last_result)
);
